/* rtl/hpmc_pkg.sv */
// ----------------------------------------------------------------------------
// hpmc_pkg
// Shared constants and types for the half-pel motion compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpmc_pkg;

   localparam int MaxRowPixels = 16;
   localparam int NarrowPixels = 8;
   localparam int RowBytes     = MaxRowPixels + 1;
   localparam int PixelWidth   = 8;
   localparam int WordWidth    = 64;

   typedef logic [PixelWidth-1:0] pixel_type;

   // interpolation controls shared by all lanes
   typedef struct packed {
      logic average_mode;
      logic half_x;
      logic half_y;
   } mode_type;

   typedef struct packed {
      logic [WordWidth-1:0] pred_low;
      logic [WordWidth-1:0] pred_high;
      logic                 block_done;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/half_pel_motion_comp.sv */
// ----------------------------------------------------------------------------
// half_pel_motion_comp
// Row-by-row half-pel prediction for 8 or 16 pixel wide blocks.
// ----------------------------------------------------------------------------
// Sixteen pixel lanes compute each row combinationally into the result buffer.
// Throughput: one row per cycle while req_stall is low.
// A two-entry result buffer keeps accepting while one result waits downstream;
// req_stall rises only when both entries are occupied.
// Priming rows (half_y with first_row) update the row store and give no beat.
// Reset empties the result buffer and clears the stored previous row to zero.
`default_nettype none

module half_pel_motion_comp (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_ref_low,
   input  wire  [63:0] req_ref_high,
   input  wire  [7:0]  req_ref_extra,
   input  wire  [63:0] req_dest_low,
   input  wire  [63:0] req_dest_high,
   input  wire         req_average_mode,
   input  wire         req_half_x,
   input  wire         req_half_y,
   input  wire         req_wide,
   input  wire         req_first_row,
   input  wire         req_last_row,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_pred_low,
   output logic [63:0] rsp_pred_high,
   output logic        rsp_block_done
);

   localparam int Rows = hpmc_pkg::RowBytes;
   localparam int Pw   = hpmc_pkg::PixelWidth;

   hpmc_pkg::pixel_type cur     [Rows];
   hpmc_pkg::pixel_type dst     [hpmc_pkg::MaxRowPixels];
   hpmc_pkg::pixel_type pred    [hpmc_pkg::MaxRowPixels];
   hpmc_pkg::pixel_type prev_ff [Rows];
   hpmc_pkg::mode_type  mode;
   hpmc_pkg::rsp_type   push_data;
   hpmc_pkg::rsp_type   rsp_data;
   logic                accept;
   logic                push;
   logic                full;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && !(req_half_y && req_first_row);

   assign mode.average_mode = req_average_mode;
   assign mode.half_x       = req_half_x;
   assign mode.half_y       = req_half_y;

   assign cur[Rows-1] = req_ref_extra;

   for (genvar i = 0; i < hpmc_pkg::MaxRowPixels; i++) begin : g_lane
      if (i < hpmc_pkg::NarrowPixels) begin : g_low
         assign cur[i]                   = req_ref_low[i*Pw +: Pw];
         assign dst[i]                   = req_dest_low[i*Pw +: Pw];
         assign push_data.pred_low[i*Pw +: Pw] = pred[i];
      end else begin : g_high
         localparam int J = i - hpmc_pkg::NarrowPixels;
         assign cur[i]                    = req_ref_high[J*Pw +: Pw];
         assign dst[i]                    = req_dest_high[J*Pw +: Pw];
         assign push_data.pred_high[J*Pw +: Pw] = pred[i];
      end

      hpmc_lane u_lane (
         .cur_a   (cur[i]),
         .cur_b   (cur[i+1]),
         .prev_c  (prev_ff[i]),
         .prev_d  (prev_ff[i+1]),
         .dst     (dst[i]),
         .mode    (mode),
         .lane_en ((i < hpmc_pkg::NarrowPixels) || req_wide),
         .pred    (pred[i])
      );
   end

   assign push_data.block_done = req_last_row;

   // every accepted row, priming or not, becomes the row above for the next
   always_ff @(posedge clock) begin
      for (int k = 0; k < Rows; k++) begin
         if (reset) begin
            prev_ff[k] <= '0;
         end else if (accept) begin
            prev_ff[k] <= cur[k];
         end
      end
   end

   hpmc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_pred_low   = rsp_data.pred_low;
   assign rsp_pred_high  = rsp_data.pred_high;
   assign rsp_block_done = rsp_data.block_done;

   a_row_store_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (prev_ff[Rows-1] == $past(req_ref_extra)
                  && prev_ff[0] == $past(req_ref_low[Pw-1:0])))
      else $error("row store not loaded from accepted row");

   a_narrow_high_zero: assert property (@(posedge clock) disable iff (reset)
      (push && !req_wide) |-> (push_data.pred_high == '0))
      else $error("narrow row produced nonzero high pixels");

   a_priming_no_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_half_y && req_first_row) |-> !push)
      else $error("priming row produced a result beat");

endmodule

`default_nettype wire

/* rtl/hpmc_lane.sv */
// ----------------------------------------------------------------------------
// hpmc_lane
// One pixel of half-pel interpolation with optional destination averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_lane (
   input  var hpmc_pkg::pixel_type cur_a,
   input  var hpmc_pkg::pixel_type cur_b,
   input  var hpmc_pkg::pixel_type prev_c,
   input  var hpmc_pkg::pixel_type prev_d,
   input  var hpmc_pkg::pixel_type dst,
   input  var hpmc_pkg::mode_type  mode,
   input  wire                     lane_en,
   output hpmc_pkg::pixel_type     pred
);

   logic [9:0]          quad_sum;
   logic [8:0]          pair_sum;
   logic [8:0]          avg_sum;
   hpmc_pkg::pixel_type pair_op;
   hpmc_pkg::pixel_type interp;

   always_comb begin
      quad_sum = {2'b00, cur_a} + {2'b00, cur_b} + {2'b00, prev_c} + {2'b00, prev_d}
               + 10'd2;
      // horizontal pair uses the right neighbor, vertical pair the row above
      pair_op  = mode.half_x ? cur_b : prev_c;
      pair_sum = {1'b0, cur_a} + {1'b0, pair_op} + 9'd1;
      unique case ({mode.half_x, mode.half_y})
         2'b11:   interp = quad_sum[9:2];
         2'b10,
         2'b01:   interp = pair_sum[8:1];
         default: interp = cur_a;
      endcase
      avg_sum = {1'b0, dst} + {1'b0, interp} + 9'd1;
      if (!lane_en) begin
         pred = '0;
      end else if (mode.average_mode) begin
         pred = avg_sum[8:1];
      end else begin
         pred = interp;
      end
   end

endmodule

`default_nettype wire

/* rtl/hpmc_rsp_buf.sv */
// ----------------------------------------------------------------------------
// hpmc_rsp_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_rsp_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  var hpmc_pkg::rsp_type  push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output hpmc_pkg::rsp_type      rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   hpmc_pkg::rsp_type out_data_ff, out_data_in;
   hpmc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("beat pushed into full result buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && !skid_valid_ff
                                  && out_data_ff == $past(skid_data_ff)))
      else $error("skid entry not moved to output register");

endmodule

`default_nettype wire

/* tb/sv/half_pel_motion_comp_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pel_motion_comp_test
// Self-checking bench for the half-pel prediction engine. Reference rows are
// streamed through the request channel. The rows are directed corner cases
// first, then well-formed random blocks mixed with loose noise rows. A row
// scoreboard keeps its own copy of the previous row and predicts every
// result beat. Both channels idle at random, with one long steady stretch.
// ----------------------------------------------------------------------------
module half_pel_motion_comp_test;

   localparam int ClockHalf  = 4;
   localparam int ResetLen   = 9;
   localparam int RowTarget  = 900;
   localparam int CycleLimit = 100000;
   localparam int IdlePct    = 8;
   localparam int DrainWait  = 6;
   localparam int Ww         = hpmc_pkg::WordWidth;
   localparam int Narrow     = hpmc_pkg::NarrowPixels;

   typedef struct {
      logic [Ww-1:0]        ref_low;
      logic [Ww-1:0]        ref_high;
      hpmc_pkg::pixel_type  ref_extra;
      logic [Ww-1:0]        dest_low;
      logic [Ww-1:0]        dest_high;
      logic                 average_mode;
      logic                 half_x;
      logic                 half_y;
      logic                 wide;
      logic                 first_row;
      logic                 last_row;
   } row_item_type;

   // Predicts result rows from accepted reference rows and checks the beats.
   class row_scoreboard;
      hpmc_pkg::pixel_type prior_row[hpmc_pkg::RowBytes];
      hpmc_pkg::rsp_type   expected_beats[$];
      int                  mismatches;
      int                  rows_noted;
      int                  primes_noted;
      int                  beats_checked;

      function new();
         foreach (prior_row[i]) prior_row[i] = '0;
         mismatches    = 0;
         rows_noted    = 0;
         primes_noted  = 0;
         beats_checked = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void note_row(row_item_type it);
         hpmc_pkg::pixel_type cur_row[hpmc_pkg::RowBytes];
         hpmc_pkg::rsp_type   pred;
         int                  lanes;
         int                  i;
         int unsigned         a, b, c, d, p, dst;
         rows_noted++;
         for (i = 0; i < Narrow; i++) begin
            cur_row[i]          = it.ref_low[8*i +: 8];
            cur_row[i + Narrow] = it.ref_high[8*i +: 8];
         end
         cur_row[hpmc_pkg::RowBytes-1] = it.ref_extra;
         // priming row: store only, no beat
         if (it.half_y && it.first_row) begin
            prior_row = cur_row;
            primes_noted++;
            return;
         end
         lanes = it.wide ? hpmc_pkg::MaxRowPixels : Narrow;
         pred  = '0;
         for (i = 0; i < lanes; i++) begin
            a = 32'(cur_row[i]);
            b = 32'(cur_row[i+1]);
            c = 32'(prior_row[i]);
            d = 32'(prior_row[i+1]);
            if (it.half_x && it.half_y) p = (a + b + c + d + 2) >> 2;
            else if (it.half_x)         p = (a + b + 1) >> 1;
            else if (it.half_y)         p = (c + a + 1) >> 1;
            else                        p = a;
            if (it.average_mode) begin
               dst = (i < Narrow) ? 32'(it.dest_low[8*i +: 8])
                                  : 32'(it.dest_high[8*(i-Narrow) +: 8]);
               p = (dst + p + 1) >> 1;
            end
            if (i < Narrow) pred.pred_low[8*i +: 8] = p[7:0];
            else            pred.pred_high[8*(i-Narrow) +: 8] = p[7:0];
         end
         pred.block_done = it.last_row;
         prior_row = cur_row;
         expected_beats.push_back(pred);
      endfunction

      task check_beat(logic [Ww-1:0] pred_low, logic [Ww-1:0] pred_high,
                      logic block_done);
         hpmc_pkg::rsp_type want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, low %h",
                                      pred_low));
            return;
         end
         want = expected_beats.pop_front();
         if (pred_low !== want.pred_low)
            report_mismatch($sformatf("pred_low %h, want %h", pred_low, want.pred_low));
         if (pred_high !== want.pred_high)
            report_mismatch($sformatf("pred_high %h, want %h", pred_high, want.pred_high));
         if (block_done !== want.block_done)
            report_mismatch($sformatf("block_done %b, want %b", block_done,
                                      want.block_done));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_ref_low = '0;
   logic [63:0] req_ref_high = '0;
   logic [7:0]  req_ref_extra = '0;
   logic [63:0] req_dest_low = '0;
   logic [63:0] req_dest_high = '0;
   logic        req_average_mode = 1'b0;
   logic        req_half_x = 1'b0;
   logic        req_half_y = 1'b0;
   logic        req_wide = 1'b0;
   logic        req_first_row = 1'b0;
   logic        req_last_row = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_pred_low;
   logic [63:0] rsp_pred_high;
   logic        rsp_block_done;

   row_scoreboard sb = new();
   bit            steady = 1'b0;
   int            cycles = 0;
   int            blocks_sent = 0;

   half_pel_motion_comp u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ref_low      (req_ref_low),
      .req_ref_high     (req_ref_high),
      .req_ref_extra    (req_ref_extra),
      .req_dest_low     (req_dest_low),
      .req_dest_high    (req_dest_high),
      .req_average_mode (req_average_mode),
      .req_half_x       (req_half_x),
      .req_half_y       (req_half_y),
      .req_wide         (req_wide),
      .req_first_row    (req_first_row),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pred_low     (rsp_pred_low),
      .rsp_pred_high    (rsp_pred_high),
      .rsp_block_done   (rsp_block_done)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d beats pending", cycles,
                  sb.expected_beats.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_pred_low, rsp_pred_high, rsp_block_done);
         rsp_stall <= !steady && ($urandom_range(99) < IdlePct);
      end
   end

   function automatic logic [63:0] pixel_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic row_item_type random_row(bit avg, bit hx, bit hy, bit wd, bit first,
                                                bit last);
      row_item_type it;
      it.ref_low      = pixel_word();
      it.ref_high     = pixel_word();
      it.ref_extra    = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(255));
      it.dest_low     = pixel_word();
      it.dest_high    = pixel_word();
      it.average_mode = avg;
      it.half_x       = hx;
      it.half_y       = hy;
      it.wide         = wd;
      it.first_row    = first;
      it.last_row     = last;
      return it;
   endfunction

   // hold the beat until it is taken; valid is only dropped on an idle cycle
   task automatic send_row(row_item_type it);
      while (!steady && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ref_low      <= it.ref_low;
      req_ref_high     <= it.ref_high;
      req_ref_extra    <= it.ref_extra;
      req_dest_low     <= it.dest_low;
      req_dest_high    <= it.dest_high;
      req_average_mode <= it.average_mode;
      req_half_x       <= it.half_x;
      req_half_y       <= it.half_y;
      req_wide         <= it.wide;
      req_first_row    <= it.first_row;
      req_last_row     <= it.last_row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_row(it);
   endtask

   initial begin
      row_item_type it;
      bit [3:0]     m;
      bit           avg, hx, hy, wd;
      int           height, rows, r;

      repeat (ResetLen) @(posedge clock);
      reset <= 1'b0;

      // vertical interpolation against the cleared row store
      it = random_row(0, 0, 1, 1, 0, 0);
      it.ref_low = '1; it.ref_high = '1; it.ref_extra = 8'hFF;
      send_row(it);
      // priming row with all zero pixels
      it = random_row(0, 0, 1, 0, 1, 0);
      it.ref_low = '0; it.ref_high = '0; it.ref_extra = '0;
      send_row(it);
      // four-pixel mean of a full-scale row over the zeroed row above, averaged with zero destination
      it = random_row(1, 1, 1, 1, 0, 1);
      it.ref_low = '1; it.ref_high = '1; it.ref_extra = 8'hFF;
      it.dest_low = '0; it.dest_high = '0;
      send_row(it);
      // first row without half_y still gives a beat
      it = random_row(1, 0, 0, 1, 1, 1);
      it.ref_low = '0; it.ref_high = '0; it.ref_extra = '0;
      it.dest_low = '1; it.dest_high = '1;
      send_row(it);
      // narrow half_x: pixel 7 pairs with ref_high byte 0, upper lanes zero
      it = random_row(0, 1, 0, 0, 0, 1);
      it.ref_low = '1; it.ref_high = 64'hFF; it.dest_high = '1;
      send_row(it);
      // every mode in both widths
      for (int k = 0; k < 16; k++) begin
         m  = k[3:0];
         it = random_row(m[0], m[1], m[2], m[3], 1'b0, m[0]);
         send_row(it);
      end

      // random blocks, with some loose rows mixed in
      while (sb.rows_noted < RowTarget) begin
         steady = (sb.rows_noted >= 300) && (sb.rows_noted < 480);
         if ($urandom_range(99) < 12) begin
            it = random_row(1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            send_row(it);
         end else begin
            avg    = 1'($urandom_range(1));
            hx     = 1'($urandom_range(1));
            hy     = 1'($urandom_range(1));
            wd     = 1'($urandom_range(1));
            height = ($urandom_range(3) == 0) ? int'($urandom_range(1, 16)) : (wd ? 16 : 8);
            rows   = height + int'(hy);
            for (r = 0; r < rows; r++) begin
               it = random_row(avg, hx, hy, wd, r == 0, r == rows - 1);
               send_row(it);
            end
            blocks_sent++;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("%0d rows sent (%0d priming, %0d random blocks), %0d result beats checked",
               sb.rows_noted, sb.primes_noted, blocks_sent, sb.beats_checked);
      $display("%0d mismatches over %0d cycles", sb.mismatches, cycles);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/hpmc_pkg.sv
rtl/hpmc_lane.sv
rtl/hpmc_rsp_buf.sv
rtl/half_pel_motion_comp.sv
tb/sv/half_pel_motion_comp_test.sv
